/* hw/rtl/lse_pkg.sv */
// Shared constants and types for the strip lightning effect.
// No dependencies; every other file of the block imports this package.
package lse_pkg;

   // strip geometry (2 to 64 pixels)
   localparam int PIXELS  = 32;

   // field widths
   localparam int CALL_W  = 32;
   localparam int POS_W   = 6;
   localparam int DELAY_W = 8;
   localparam int LEVEL_W = 8;
   localparam int IDX_W   = 6;

   // update ticks are multiples of TICK_DIV
   localparam int TICK_DIV  = 10;
   localparam int NIBBLES   = CALL_W / 4;
   localparam int NIB_CNT_W = $clog2(NIBBLES);
   localparam int RES_W     = 4;

   localparam logic [LEVEL_W-1:0] STRIKE_LEVEL = 8'd255;
   localparam int LEVEL_MAX   = 209;
   localparam int DECAY_SHIFT = 3;

   // floor(7*x/10) for 8-bit x as (x * SEV_MULT) >> SEV_SHIFT
   localparam int SEV_SHIFT = 16;
   localparam int SEV_MULT  = 45878;
   localparam int SEV_W     = LEVEL_W + SEV_SHIFT;

   // strike position modulo PIXELS by reciprocal, exact for positions below 64
   localparam int RECIP_SHIFT = 12;
   localparam int RECIP_W     = 13;
   localparam int POS_RECIP   = ((1 << RECIP_SHIFT) + PIXELS - 1) / PIXELS;

   typedef struct packed {
      logic shift;
      logic strike;
   } lse_cell_ctrl_type;

   typedef struct packed {
      logic done;
      logic multiple;
   } lse_mod_status_type;

   typedef struct packed {
      logic step;
      logic first;
      logic last;
   } lse_step_type;

endpackage

/* hw/rtl/lse_cell.sv */
// One pixel cell of the strip ring: holds a level, takes a strike or its
// neighbour's level. Depends on lse_pkg.
module lse_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  lse_pkg::lse_cell_ctrl_type     ctrl,
   input  logic                           hit,
   input  logic [lse_pkg::LEVEL_W-1:0]    shift_in,
   output logic [lse_pkg::LEVEL_W-1:0]    level
);
   import lse_pkg::*;

   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;

   always_comb begin
      priority if (ctrl.strike && hit) begin
         level_in = STRIKE_LEVEL;
      end else if (ctrl.shift) begin
         level_in = shift_in;
      end else begin
         level_in = level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

/* hw/rtl/lse_mod10.sv */
// Residue of the tick number modulo ten, one nibble per cycle from the top.
// Depends on lse_pkg.
module lse_mod10 (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lse_pkg::CALL_W-1:0]    value,
   output lse_pkg::lse_mod_status_type   status
);
   import lse_pkg::*;

   logic [CALL_W-1:0]    sh_ff, sh_in;
   logic [RES_W-1:0]     res_ff, res_in;
   logic [NIB_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [6:0]           t;

   // 16*r == 6*r modulo ten, so t stays below seven tens
   always_comb begin
      t = 7'(res_ff) * 7'd6 + 7'(sh_ff[CALL_W-1 -: 4]);
      priority if (t >= 7'(6 * TICK_DIV)) begin
         res_in = RES_W'(t - 7'(6 * TICK_DIV));
      end else if (t >= 7'(5 * TICK_DIV)) begin
         res_in = RES_W'(t - 7'(5 * TICK_DIV));
      end else if (t >= 7'(4 * TICK_DIV)) begin
         res_in = RES_W'(t - 7'(4 * TICK_DIV));
      end else if (t >= 7'(3 * TICK_DIV)) begin
         res_in = RES_W'(t - 7'(3 * TICK_DIV));
      end else if (t >= 7'(2 * TICK_DIV)) begin
         res_in = RES_W'(t - 7'(2 * TICK_DIV));
      end else if (t >= 7'(TICK_DIV)) begin
         res_in = RES_W'(t - 7'(TICK_DIV));
      end else begin
         res_in = RES_W'(t);
      end

      sh_in   = sh_ff << 4;
      cnt_in  = cnt_ff + 1'b1;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         sh_in   = value;
         res_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == NIB_CNT_W'(NIBBLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         sh_in  = sh_ff;
         res_in = res_ff;
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      res_ff <= res_in;
   end

   assign status.done     = done_ff;
   assign status.multiple = (res_ff == '0);

endmodule

/* hw/rtl/lse_glow.sv */
// Per-pixel glow unit: gradient sign, decay and spread from a neighbour,
// with a window on the previous old level and new level. Depends on lse_pkg.
module lse_glow (
   input  logic                          clock,
   input  lse_pkg::lse_step_type         ctrl,
   input  logic [lse_pkg::LEVEL_W-1:0]   cur,
   input  logic [lse_pkg::LEVEL_W-1:0]   nxt,
   output logic [lse_pkg::LEVEL_W-1:0]   nb
);
   import lse_pkg::*;

   logic [LEVEL_W-1:0] prev_ff;
   logic [LEVEL_W-1:0] left_nb_ff;
   logic               up, down;
   logic [LEVEL_W-1:0] op;
   logic [SEV_W-1:0]   sev_prod;
   logic [LEVEL_W-1:0] sev;

   // interior: half the difference is non-zero only when it is two or more
   always_comb begin
      priority if (ctrl.first) begin
         up   = nxt > cur;
         down = nxt < cur;
      end else if (ctrl.last) begin
         up   = cur > prev_ff;
         down = cur < prev_ff;
      end else begin
         up   = 9'(nxt) > 9'(prev_ff) + 9'd1;
         down = 9'(prev_ff) > 9'(nxt) + 9'd1;
      end

      op       = up ? nxt : left_nb_ff;
      sev_prod = SEV_W'(op) * SEV_W'(SEV_MULT);
      sev      = sev_prod[SEV_SHIFT +: LEVEL_W];

      nb = cur >> DECAY_SHIFT;
      if ((up && !ctrl.last) || (down && !ctrl.first)) begin
         nb = nb + sev;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.step) begin
         prev_ff    <= cur;
         left_nb_ff <= nb;
      end
   end

endmodule

/* hw/rtl/led_strip_lightning_effect.sv */
// Lightning effect for a strip of PIXELS pixels. A request is one tick; the
// block takes it when idle, finds the tick number modulo ten (one nibble
// a cycle) and drops the request there if it is not a multiple of ten. An
// update tick then goes through a strike state and a run state, in which
// the ring of pixel cells rotates through the glow unit one pixel a step;
// a step waits while a response is stalled. A new request is taken only
// once the last pixel of the frame has been stepped out. Responses come in
// pixel order, last_pixel marking the final pixel. Depends on lse_pkg,
// lse_cell, lse_mod10 and lse_glow.
module led_strip_lightning_effect (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lse_pkg::CALL_W-1:0]    req_call_number,
   input  logic [lse_pkg::POS_W-1:0]     req_strike_position,
   input  logic [lse_pkg::DELAY_W-1:0]   req_strike_delay,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lse_pkg::IDX_W-1:0]     rsp_pixel_index,
   output logic [lse_pkg::LEVEL_W-1:0]   rsp_pixel_level,
   output logic                          rsp_last_pixel
);
   import lse_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_MOD    = 2'd1;
   localparam logic [1:0] S_STRIKE = 2'd2;
   localparam logic [1:0] S_RUN    = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CALL_W-1:0]  call_ff, call_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [POS_W-1:0]   strike_idx_ff, strike_idx_in;
   logic [CALL_W-1:0]  next_ff, next_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic               rsp_last_ff, rsp_last_in;

   logic                       accept;
   logic                       strike_now;
   logic [POS_W+RECIP_W-1:0]   pos_prod;
   logic [POS_W-1:0]           pos_q;
   logic [POS_W-1:0]           pos_rem;
   lse_mod_status_type         mod_status;
   lse_cell_ctrl_type          cell_ctrl;
   lse_step_type               step_ctrl;
   logic [LEVEL_W-1:0]         nb;
   logic [LEVEL_W-1:0]         cell_level [PIXELS];

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // strike position modulo the strip length by reciprocal multiply
   always_comb begin
      pos_prod = (POS_W+RECIP_W)'(req_strike_position) * (POS_W+RECIP_W)'(POS_RECIP);
      pos_q    = pos_prod[RECIP_SHIFT +: POS_W];
      pos_rem  = req_strike_position - pos_q * POS_W'(PIXELS);
   end

   assign strike_now = (call_ff >= next_ff);

   always_comb begin
      state_in      = state_ff;
      call_in       = call_ff;
      delay_in      = delay_ff;
      strike_idx_in = strike_idx_ff;
      next_in       = next_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_index_in  = rsp_index_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_last_in   = rsp_last_ff;

      step_ctrl.step  = (state_ff == S_RUN) && (!rsp_valid_ff || rsp_ready);
      step_ctrl.first = (idx_ff == '0);
      step_ctrl.last  = (idx_ff == IDX_W'(PIXELS - 1));
      cell_ctrl.shift  = step_ctrl.step;
      cell_ctrl.strike = (state_ff == S_STRIKE) && strike_now;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               call_in       = req_call_number;
               delay_in      = req_strike_delay;
               strike_idx_in = pos_rem;
               state_in      = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_status.done) begin
               state_in = mod_status.multiple ? S_STRIKE : S_IDLE;
            end
         end
         S_STRIKE: begin
            if (strike_now) begin
               next_in = call_ff + CALL_W'(delay_ff);
            end
            idx_in   = '0;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (step_ctrl.step) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_ff;
               rsp_level_in = nb;
               rsp_last_in  = step_ctrl.last;
               idx_in       = idx_ff + 1'b1;
               if (step_ctrl.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_ff      <= next_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      call_ff       <= call_in;
      delay_ff      <= delay_in;
      strike_idx_ff <= strike_idx_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_last_ff   <= rsp_last_in;
   end

   lse_mod10 u_mod10 (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .value  (req_call_number),
      .status (mod_status)
   );

   // cell 0 holds the pixel under work, cell 1 its right neighbour;
   // new levels enter at the tail, so after a frame the ring is in order again
   for (genvar k = 0; k < PIXELS; k++) begin : g_cell
      logic [LEVEL_W-1:0] shift_in;
      if (k == PIXELS - 1) begin : g_tail
         assign shift_in = nb;
      end else begin : g_body
         assign shift_in = cell_level[k+1];
      end
      lse_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .hit      (strike_idx_ff == IDX_W'(k)),
         .shift_in (shift_in),
         .level    (cell_level[k])
      );
   end

   lse_glow u_glow (
      .clock (clock),
      .ctrl  (step_ctrl),
      .cur   (cell_level[0]),
      .nxt   (cell_level[1]),
      .nb    (nb)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_index = rsp_index_ff;
   assign rsp_pixel_level = rsp_level_ff;
   assign rsp_last_pixel  = rsp_last_ff;

endmodule

/* hw/rtl/lse_checker.sv */
// Port-level checks for the strip lightning effect, bound to its top level.
// Depends on lse_pkg and led_strip_lightning_effect.
module lse_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [lse_pkg::IDX_W-1:0]     rsp_pixel_index,
   input  logic [lse_pkg::LEVEL_W-1:0]   rsp_pixel_level,
   input  logic                          rsp_last_pixel
);
   import lse_pkg::*;

   // a request keeps the block busy for the next cycle at least
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   // the frame marker sits on the final pixel and nowhere else
   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_pixel == (rsp_pixel_index == IDX_W'(PIXELS - 1))))
      else $error("last_pixel does not match the final pixel index");

   // decay plus spread never passes the ceiling
   a_level_ceiling: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel_level <= LEVEL_W'(LEVEL_MAX)))
      else $error("pixel level above the decay ceiling");

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pixel_index) && $stable(rsp_pixel_level)
         && $stable(rsp_last_pixel))
      else $error("stalled response changed");

endmodule

bind led_strip_lightning_effect lse_checker u_lse_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pixel_index (rsp_pixel_index),
   .rsp_pixel_level (rsp_pixel_level),
   .rsp_last_pixel  (rsp_last_pixel)
);

/* tb/tb_top.sv */
// Self-checking testbench for led_strip_lightning_effect: directed and random ticks,
// with every emitted pixel checked against a frame predictor held in a scoreboard class.
// Depends on lse_pkg and the led_strip_lightning_effect RTL.
`timescale 1ns / 1ps

typedef struct packed {
   logic [lse_pkg::IDX_W-1:0]   index;
   logic [lse_pkg::LEVEL_W-1:0] level;
   logic                        last;
} pixel_result_type;

class glow_scoreboard;
   logic [lse_pkg::LEVEL_W-1:0] glow [lse_pkg::PIXELS];
   logic [lse_pkg::CALL_W-1:0]  strike_due;
   pixel_result_type            pending_pixels [$];
   int                          failures;

   function new();
      foreach (glow[i]) glow[i] = '0;
      strike_due = '0;
      failures   = 0;
   endfunction

   // Works out the frame a request produces and queues its pixels.
   function void note_tick(logic [lse_pkg::CALL_W-1:0]  call,
                           logic [lse_pkg::POS_W-1:0]   pos,
                           logic [lse_pkg::DELAY_W-1:0] delay);
      logic [lse_pkg::LEVEL_W-1:0] lit   [lse_pkg::PIXELS];
      logic [lse_pkg::LEVEL_W-1:0] fresh [lse_pkg::PIXELS];
      int               slope;
      int               sum;
      pixel_result_type item;
      if (call % lse_pkg::TICK_DIV != 0) return;
      lit = glow;
      if (call >= strike_due) begin
         lit[pos % lse_pkg::PIXELS] = lse_pkg::STRIKE_LEVEL;
         strike_due = call + lse_pkg::CALL_W'(delay);
      end
      for (int i = 0; i < lse_pkg::PIXELS; i++) begin
         if (i == 0)
            slope = int'(lit[1]) - int'(lit[0]);
         else if (i == lse_pkg::PIXELS - 1)
            slope = int'(lit[i]) - int'(lit[i-1]);
         else
            slope = (int'(lit[i+1]) - int'(lit[i-1])) / 2;
         sum = int'(lit[i]) / 8;
         // rising side borrows from the old right pixel, falling side from the new left one
         if (slope > 0 && i < lse_pkg::PIXELS - 1)
            sum += int'(lit[i+1]) * 7 / 10;
         else if (slope < 0 && i > 0)
            sum += int'(fresh[i-1]) * 7 / 10;
         fresh[i]   = lse_pkg::LEVEL_W'(sum);
         item.index = lse_pkg::IDX_W'(i);
         item.level = fresh[i];
         item.last  = (i == lse_pkg::PIXELS - 1);
         pending_pixels.push_back(item);
      end
      glow = fresh;
   endfunction

   function void check_pixel(logic [lse_pkg::IDX_W-1:0]   index,
                             logic [lse_pkg::LEVEL_W-1:0] level,
                             logic                        last);
      pixel_result_type want;
      if (pending_pixels.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected pixel: idx %0d level %0d last %0b", index, level, last);
         return;
      end
      want = pending_pixels.pop_front();
      if (index !== want.index || level !== want.level || last !== want.last) begin
         failures++;
         if (failures <= 10)
            $display({"pixel mismatch: want idx %0d level %0d last %0b,",
                      " got idx %0d level %0d last %0b"},
                     want.index, want.level, want.last, index, level, last);
      end
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_TICKS = 72;
   localparam longint TOP_TICK = 64'd4294967290;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [lse_pkg::CALL_W-1:0]      req_call_number = '0;
   logic [lse_pkg::POS_W-1:0]       req_strike_position = '0;
   logic [lse_pkg::DELAY_W-1:0]     req_strike_delay = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [lse_pkg::IDX_W-1:0]       rsp_pixel_index;
   logic [lse_pkg::LEVEL_W-1:0]     rsp_pixel_level;
   logic                            rsp_last_pixel;

   int             send_idle_pct = 23;
   int             recv_idle_pct = 55;
   int             cycles = 0;
   glow_scoreboard sb;

   led_strip_lightning_effect dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_call_number     (req_call_number),
      .req_strike_position (req_strike_position),
      .req_strike_delay    (req_strike_delay),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pixel_index     (rsp_pixel_index),
      .rsp_pixel_level     (rsp_pixel_level),
      .rsp_last_pixel      (rsp_last_pixel)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_pixel(rsp_pixel_index, rsp_pixel_level, rsp_last_pixel);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("led_strip_lightning_effect regression: fail");
         $finish;
      end
   end

   task automatic send_tick(input logic [lse_pkg::CALL_W-1:0]  call,
                            input logic [lse_pkg::POS_W-1:0]   pos,
                            input logic [lse_pkg::DELAY_W-1:0] delay);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_call_number     <= call;
      req_strike_position <= pos;
      req_strike_delay    <= delay;
      do @(posedge clock); while (!req_ready);
      sb.note_tick(call, pos, delay);
   endtask

   initial begin
      longint          tick;
      int              updates;
      int              pick;
      logic [31:0]     noise;
      logic [7:0]      delay;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: strikes, missed strikes, folded positions, idle ticks, wrap of the due tick
      send_tick(32'd0, 6'd0, 8'd230);
      send_tick(32'd10, 6'd5, 8'd0);
      send_tick(32'd7, 6'd63, 8'd230);
      send_tick(32'd230, 6'd31, 8'd0);
      send_tick(32'd230, 6'd63, 8'd0);
      send_tick(32'd240, 6'd32, 8'd10);
      send_tick(32'd250, 6'd1, 8'd100);
      send_tick(32'd260, 6'd40, 8'd3);
      send_tick(32'd270, 6'd2, 8'd3);
      send_tick(32'd280, 6'd9, 8'd3);
      send_tick(32'd290, 6'd63, 8'd3);
      send_tick(32'd4294967295, 6'd0, 8'd0);
      send_tick(32'd4294967290, 6'd45, 8'd230);
      send_tick(32'd220, 6'd10, 8'd5);
      send_tick(32'd230, 6'd20, 8'd230);
      send_tick(32'd13, 6'd17, 8'd1);
      send_tick(32'd240, 6'd16, 8'd255);
      send_tick(32'd250, 6'd16, 8'd127);
      send_tick(32'd260, 6'd33, 8'd24);
      send_tick(32'd470, 6'd15, 8'd0);

      tick = 500;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 55 : 0;
         recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 23 : 0;
         updates = 0;
         while (updates < PHASE_TICKS) begin
            if ($urandom_range(0, 99) < 12) begin
               noise = $urandom();
               if (noise % 10 == 0) noise = noise + 1;
               send_tick(noise, 6'($urandom_range(0, 63)), 8'($urandom_range(0, 230)));
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
               tick = longint'($urandom() / 10) * 10;
            else if (pick < 8)
               tick = TOP_TICK - 10 * $urandom_range(0, 30);
            else begin
               tick = tick + 10 * $urandom_range(1, 3);
               if (tick > TOP_TICK) tick = 10 * $urandom_range(0, 5);
            end
            // a distant due tick would starve the strip of strikes
            if (longint'(sb.strike_due) > tick + 300 && $urandom_range(0, 3) != 0) begin
               tick = ((longint'(sb.strike_due) + 9) / 10) * 10;
               if (tick > TOP_TICK) tick = TOP_TICK;
            end
            delay = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 40))
                                               : 8'($urandom_range(0, 230));
            send_tick(32'(tick), 6'($urandom_range(0, 63)), delay);
            updates++;
         end
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.failures == 0)
         $display("led_strip_lightning_effect regression: pass");
      else
         $display("led_strip_lightning_effect regression: fail");
      $finish;
   end
endmodule
